// ===== rtl/core/att_pkg.sv =====
// shared types and constants of the alarm table timer
`default_nettype none

package att_pkg;

    localparam int TICK_W      = 16;
    localparam int ID_W        = 8;
    localparam int OP_W        = 3;
    localparam int ST_W        = 3;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_SETREL = 3'd1;
    localparam logic [OP_W-1:0] OP_SETABS = 3'd2;
    localparam logic [OP_W-1:0] OP_CANCEL = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

    localparam logic [ST_W-1:0] STAT_OK       = 3'd0;
    localparam logic [ST_W-1:0] STAT_BAD_ID   = 3'd1;
    localparam logic [ST_W-1:0] STAT_BAD_VAL  = 3'd2;
    localparam logic [ST_W-1:0] STAT_ACTIVE   = 3'd3;
    localparam logic [ST_W-1:0] STAT_INACTIVE = 3'd4;

    localparam logic CFG_WRAP_LIMIT = 1'b0;
    localparam logic CFG_MIN_CYCLE  = 1'b1;

    localparam logic [TICK_W-1:0] WRAP_LIMIT_RST = 16'hFFFF;
    localparam logic [TICK_W-1:0] MIN_CYCLE_RST  = 16'd1;

    typedef struct packed {
        logic              active;
        logic [TICK_W-1:0] expiry;
        logic [TICK_W-1:0] period;
    } alarm_rec_t;

endpackage

`default_nettype wire

// ===== rtl/core/att_cell.sv =====
// one cell of the alarm ring: holds one alarm record, passes it on when shifted
`default_nettype none

module att_cell
    import att_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift,
    input  wire alarm_rec_t rec_in,
    output alarm_rec_t      rec
);

    logic              active_reg;
    logic [TICK_W-1:0] expiry_reg;
    logic [TICK_W-1:0] period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (shift)
        begin
            active_reg <= rec_in.active;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            expiry_reg <= rec_in.expiry;
            period_reg <= rec_in.period;
        end
    end

    assign rec = {active_reg, expiry_reg, period_reg};

endmodule

`default_nettype wire

// ===== rtl/core/att_mod.sv =====
// restoring remainder unit: (a + b) mod m, one quotient bit per cycle
`default_nettype none

module att_mod
    import att_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [TICK_W-1:0] a,
    input  wire logic [TICK_W-1:0] b,
    input  wire logic [TICK_W:0]   modulus,
    output logic                   done,
    output logic [TICK_W-1:0]      result
);

    localparam int BIT_W = $clog2(TICK_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [BIT_W-1:0] cnt_reg, cnt_next;
    logic [TICK_W:0]  x_reg, x_next;
    logic [TICK_W:0]  rem_reg, rem_next;
    logic [TICK_W:0]  m_reg, m_next;
    logic [TICK_W+1:0] trial;
    logic [TICK_W+1:0] diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        rem_next  = rem_reg;
        m_next    = m_reg;
        trial     = {rem_reg, x_reg[TICK_W]};
        diff      = trial - {1'b0, m_reg};
        if (start)
        begin
            x_next    = {1'b0, a} + {1'b0, b};
            rem_next  = '0;
            m_next    = modulus;
            cnt_next  = BIT_W'(TICK_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            x_next = {x_reg[TICK_W-1:0], 1'b0};
            if (trial >= {1'b0, m_reg})
            begin
                rem_next = diff[TICK_W:0];
            end
            else
            begin
                rem_next = trial[TICK_W:0];
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        rem_reg <= rem_next;
        m_reg   <= m_next;
    end

    assign done   = done_reg;
    assign result = rem_reg[TICK_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/alarm_table_timer.sv =====
// alarm table timer top level: alarm ring, sequencer and output register
//
// A table of NUM_ALARMS alarms on one wrapping tick counter. Each alarm lives
// in a cell of a ring; every command rotates the ring once around, and the
// record passing the head is examined and rewritten by the sequencer, so the
// ring ends each command back in index order. A command passes through accept,
// one step per ring cell and result load; every accepted relative set and
// every cyclic alarm re-armed by a tick waits on the shared remainder unit,
// which retires one bit of (a + b) mod (wrap limit + 1) per cycle. A tick
// yields one result transaction per expired alarm in index order (at most
// eight are reported, all are processed), or a single result with
// expired_valid low; tlast marks the final result of each command.
// Stalls on the result side hold the ring. Configuration writes are taken
// at any time but are meant to happen only while the block is idle.
`default_nettype none

module alarm_table_timer
    import att_pkg::*;
#(
    parameter int NUM_ALARMS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // slot[7:0], tick_value[23:8], cycle_value[39:24]
    input  wire logic [2:0]  s_axis_tuser,   // opcode[2:0]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // status[2:0], ticks_left[18:3], expired_id[26:19]
    output logic             m_axis_tuser,   // expired_valid[0]
    output logic             m_axis_tlast,
    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ALARMS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MOD  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    // configuration
    logic [TICK_W-1:0] wrap_limit_reg;
    logic [TICK_W-1:0] min_cycle_reg;

    // sequencer state
    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic [TICK_W-1:0] counter_reg, counter_next;

    // latched command
    logic [OP_W-1:0]   op_reg, op_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [TICK_W-1:0] tv_reg, tv_next;
    logic [TICK_W-1:0] cyc_reg, cyc_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [TICK_W-1:0] left_reg, left_next;
    alarm_rec_t        held_reg, held_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [ST_W-1:0]   out_status_reg, out_status_next;
    logic [TICK_W-1:0] out_left_reg, out_left_next;
    logic              out_expv_reg, out_expv_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic              out_last_reg, out_last_next;

    // ring and remainder unit
    alarm_rec_t        cell_rec [NUM_ALARMS];
    alarm_rec_t        head;
    alarm_rec_t        new_rec;
    logic              shift;
    logic              emit_now;
    logic              mod_start;
    logic [TICK_W-1:0] mod_a, mod_b;
    logic              mod_done;
    logic [TICK_W-1:0] mod_res;
    logic [TICK_W:0]   modulus;

    // per-head decisions
    logic              out_free;
    logic              can_report;
    logic              emit_blocked;
    logic              match;
    logic              hit;
    logic              cyc_bad;
    logic              tv_bad;
    logic              in_range_op;
    logic [TICK_W:0]   left_wrap;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_ALARMS; gi++)
        begin : g_cell
            alarm_rec_t cell_in;
            if (gi == NUM_ALARMS - 1)
            begin : g_tail
                assign cell_in = new_rec;
            end
            else
            begin : g_body
                assign cell_in = cell_rec[gi+1];
            end
            att_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .shift  (shift),
                .rec_in (cell_in),
                .rec    (cell_rec[gi])
            );
        end
    endgenerate

    assign modulus = {1'b0, wrap_limit_reg} + 1'b1;

    att_mod u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .a       (mod_a),
        .b       (mod_b),
        .modulus (modulus),
        .done    (mod_done),
        .result  (mod_res)
    );

    assign head         = cell_rec[0];
    assign out_free     = !out_valid_reg || m_axis_tready;
    assign can_report   = cnt_reg < CNT_W'(MAX_RESULTS);
    // a new expiry pushes the held one out, which needs a free output slot
    assign emit_blocked = can_report && pend_valid_reg && !out_free;
    assign match        = head.active && (head.expiry == counter_reg);
    assign in_range_op  = (op_reg == OP_SETREL) || (op_reg == OP_SETABS) ||
                          (op_reg == OP_CANCEL) || (op_reg == OP_QUERY);
    assign hit          = in_range_op && (id_reg == ID_W'(step_reg));
    assign cyc_bad      = (cyc_reg != '0) &&
                          ((cyc_reg < min_cycle_reg) || (cyc_reg > wrap_limit_reg));
    assign tv_bad       = (tv_reg > wrap_limit_reg) ||
                          ((op_reg == OP_SETREL) && (tv_reg == '0));
    // ticks left once the counter has passed the expiry
    assign left_wrap    = modulus - {1'b0, counter_reg} + {1'b0, head.expiry};

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        counter_next    = counter_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        tv_next         = tv_reg;
        cyc_next        = cyc_reg;
        status_next     = status_reg;
        left_next       = left_reg;
        held_next       = held_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_left_next   = out_left_reg;
        out_expv_next   = out_expv_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        new_rec         = head;
        shift           = 1'b0;
        emit_now        = 1'b0;
        mod_start       = 1'b0;
        mod_a           = counter_reg;
        mod_b           = head.period;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next         = s_axis_tuser;
                    id_next         = s_axis_tdata[7:0];
                    tv_next         = s_axis_tdata[23:8];
                    cyc_next        = s_axis_tdata[39:24];
                    step_next       = '0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    left_next       = '0;
                    status_next     = STAT_OK;
                    if (((s_axis_tuser == OP_SETREL) || (s_axis_tuser == OP_SETABS) ||
                         (s_axis_tuser == OP_CANCEL) || (s_axis_tuser == OP_QUERY)) &&
                        ({1'b0, s_axis_tdata[7:0]} >= 9'(NUM_ALARMS)))
                    begin
                        status_next = STAT_BAD_ID;
                    end
                    if (s_axis_tuser == OP_TICK)
                    begin
                        // counter may sit above a lowered maximum: wrap it too
                        if (counter_reg >= wrap_limit_reg)
                        begin
                            counter_next = '0;
                        end
                        else
                        begin
                            counter_next = counter_reg + 1'b1;
                        end
                    end
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (op_reg == OP_TICK)
                begin
                    if (match && emit_blocked)
                    begin
                        shift = 1'b0;
                    end
                    else if (match && (head.period != '0))
                    begin
                        mod_start  = 1'b1;
                        mod_a      = counter_reg;
                        mod_b      = head.period;
                        held_next  = head;
                        state_next = S_MOD;
                    end
                    else
                    begin
                        shift = 1'b1;
                        if (match)
                        begin
                            new_rec.active = 1'b0;
                            emit_now       = 1'b1;
                        end
                    end
                end
                else if (hit &&
                         ((op_reg == OP_SETREL) || (op_reg == OP_SETABS)) &&
                         !tv_bad && !cyc_bad && !head.active &&
                         (op_reg == OP_SETREL))
                begin
                    mod_start        = 1'b1;
                    mod_a            = counter_reg;
                    mod_b            = tv_reg;
                    held_next.active = 1'b1;
                    held_next.expiry = tv_reg;
                    held_next.period = cyc_reg;
                    state_next       = S_MOD;
                end
                else
                begin
                    shift = 1'b1;
                    if (hit)
                    begin
                        priority if ((op_reg == OP_SETREL) || (op_reg == OP_SETABS))
                        begin
                            if (tv_bad || cyc_bad)
                            begin
                                status_next = STAT_BAD_VAL;
                            end
                            else if (head.active)
                            begin
                                status_next = STAT_ACTIVE;
                            end
                            else
                            begin
                                new_rec.active = 1'b1;
                                new_rec.expiry = tv_reg;
                                new_rec.period = cyc_reg;
                            end
                        end
                        else if (!head.active)
                        begin
                            status_next = STAT_INACTIVE;
                        end
                        else if (op_reg == OP_CANCEL)
                        begin
                            new_rec.active = 1'b0;
                        end
                        else
                        begin
                            if (counter_reg > head.expiry)
                            begin
                                left_next = left_wrap[TICK_W-1:0];
                            end
                            else
                            begin
                                left_next = head.expiry - counter_reg;
                            end
                        end
                    end
                end
            end
            S_MOD:
            begin
                if (mod_done && !((op_reg == OP_TICK) && emit_blocked))
                begin
                    new_rec        = held_reg;
                    new_rec.expiry = mod_res;
                    shift          = 1'b1;
                    emit_now       = (op_reg == OP_TICK);
                    state_next     = S_SCAN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (op_reg == OP_TICK)
                    begin
                        out_status_next = STAT_OK;
                        out_left_next   = '0;
                        out_expv_next   = pend_valid_reg;
                        out_id_next     = pend_valid_reg ? pend_id_reg : '0;
                    end
                    else
                    begin
                        out_status_next = status_reg;
                        out_left_next   = left_reg;
                        out_expv_next   = 1'b0;
                        out_id_next     = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // expired alarm report: hold the newest, send the one before it
        if (emit_now && can_report)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_status_next = STAT_OK;
                out_left_next   = '0;
                out_expv_next   = 1'b1;
                out_id_next     = pend_id_reg;
                out_last_next   = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_id_next    = ID_W'(step_reg);
            cnt_next        = cnt_reg + 1'b1;
        end

        // ring rotation bookkeeping
        if (shift)
        begin
            if (step_reg == LAST_IDX)
            begin
                step_next  = '0;
                state_next = S_FIN;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_limit_reg <= WRAP_LIMIT_RST;
            min_cycle_reg  <= MIN_CYCLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_WRAP_LIMIT: wrap_limit_reg <= cfg_wdata;
                CFG_MIN_CYCLE:  min_cycle_reg  <= cfg_wdata;
                default:        wrap_limit_reg <= wrap_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            counter_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            counter_reg    <= counter_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg    <= pend_id_next;
        op_reg         <= op_next;
        id_reg         <= id_next;
        tv_reg         <= tv_next;
        cyc_reg        <= cyc_next;
        status_reg     <= status_next;
        left_reg       <= left_next;
        held_reg       <= held_next;
        out_status_reg <= out_status_next;
        out_left_reg   <= out_left_next;
        out_expv_reg   <= out_expv_next;
        out_id_reg     <= out_id_next;
        out_last_reg   <= out_last_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_id_reg, out_left_reg, out_status_reg};
    assign m_axis_tuser  = out_expv_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// testbench of the alarm table timer: directed table, random commands, scoreboard
`timescale 1ns / 100ps

module tb_top;
    import att_pkg::*;

    localparam int NUM_ALARMS = 8;
    localparam int WATCHDOG_LIMIT = 20000;

    // one expected result transaction
    typedef struct {
        logic [ST_W-1:0]   status;
        logic [TICK_W-1:0] ticks_left;
        logic              expired_valid;
        logic [ID_W-1:0]   expired_id;
        logic              last;
    } result_t;

    // one directed row; has_exp marks rows with a typed-in single result
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] tv;
        logic [TICK_W-1:0] cyc;
        bit                has_exp;
        logic [ST_W-1:0]   exp_status;
    } cmd_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata;   // slot[7:0], tick_value[23:8], cycle_value[39:24]
    logic [2:0]        s_axis_tuser;   // opcode[2:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [31:0]       m_axis_tdata;   // status[2:0], ticks_left[18:3], expired_id[26:19]
    logic              m_axis_tuser;   // expired_valid[0]
    logic              m_axis_tlast;
    logic              cfg_we;
    logic              cfg_addr;
    logic [15:0]       cfg_wdata;

    // predictor state: configuration and alarm table
    logic [TICK_W-1:0] pred_wrap_limit;
    logic [TICK_W-1:0] pred_min_cycle;
    logic [TICK_W-1:0] pred_counter;
    logic              pred_active [NUM_ALARMS];
    logic [TICK_W-1:0] pred_expiry [NUM_ALARMS];
    logic [TICK_W-1:0] pred_period [NUM_ALARMS];

    result_t           expected_results [$];
    int                mismatch_count;
    int                idle_cycles;
    bit                timed_out;
    int                rx_count;

    alarm_table_timer #(.NUM_ALARMS(NUM_ALARMS)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // (a + b) mod (wrap limit + 1), done wide to avoid overflow
    function automatic logic [TICK_W-1:0] wrap_add(logic [TICK_W-1:0] a, logic [TICK_W-1:0] b);
        logic [17:0] m;
        m = {2'b0, pred_wrap_limit} + 18'd1;
        return TICK_W'(({2'b0, a} + {2'b0, b}) % m);
    endfunction

    function automatic bit cycle_out_of_range(logic [TICK_W-1:0] cyc);
        return cyc != 0 && (cyc < pred_min_cycle || cyc > pred_wrap_limit);
    endfunction

    function automatic result_t mk_result(logic [ST_W-1:0] st, logic [TICK_W-1:0] left,
                                          logic ev, logic [ID_W-1:0] eid, logic lst);
        result_t r;
        r.status = st;
        r.ticks_left = left;
        r.expired_valid = ev;
        r.expired_id = eid;
        r.last = lst;
        return r;
    endfunction

    // advance the alarm table by one command and queue its results
    task automatic predict_command(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                   logic [TICK_W-1:0] tv, logic [TICK_W-1:0] cyc);
        result_t     batch [$];
        logic [ST_W-1:0] st;
        logic [TICK_W-1:0] left;
        logic [17:0] m;
        bit          bad;
        st = STAT_OK;
        left = '0;
        if (op == OP_TICK)
        begin
            if (pred_counter >= pred_wrap_limit)
                pred_counter = '0;
            else
                pred_counter = pred_counter + 1'b1;
            for (int i = 0; i < NUM_ALARMS; i++)
            begin
                if (pred_active[i] && pred_expiry[i] == pred_counter)
                begin
                    if (pred_period[i] == 0)
                        pred_active[i] = 1'b0;
                    else
                        pred_expiry[i] = wrap_add(pred_counter, pred_period[i]);
                    if (batch.size() < MAX_RESULTS)
                        batch.push_back(mk_result(STAT_OK, '0, 1'b1, ID_W'(i), 1'b0));
                end
            end
            if (batch.size() == 0)
                batch.push_back(mk_result(STAT_OK, '0, 1'b0, '0, 1'b1));
            else
                batch[batch.size()-1].last = 1'b1;
            foreach (batch[k])
                expected_results.push_back(batch[k]);
            return;
        end
        if (op > OP_QUERY)
        begin
            // undefined opcodes leave the table alone
        end
        else if (id >= NUM_ALARMS)
            st = STAT_BAD_ID;
        else if (op == OP_SETREL || op == OP_SETABS)
        begin
            bad = (op == OP_SETREL) ? (tv == 0 || tv > pred_wrap_limit) : (tv > pred_wrap_limit);
            if (bad || cycle_out_of_range(cyc))
                st = STAT_BAD_VAL;
            else if (pred_active[id])
                st = STAT_ACTIVE;
            else
            begin
                pred_active[id] = 1'b1;
                pred_expiry[id] = (op == OP_SETREL) ? wrap_add(pred_counter, tv) : tv;
                pred_period[id] = cyc;
            end
        end
        else if (op == OP_CANCEL)
        begin
            if (!pred_active[id])
                st = STAT_INACTIVE;
            else
                pred_active[id] = 1'b0;
        end
        else
        begin
            if (!pred_active[id])
                st = STAT_INACTIVE;
            else
            begin
                m = {2'b0, pred_wrap_limit} + 18'd1;
                if (pred_counter > pred_expiry[id])
                    left = TICK_W'(m - pred_counter + pred_expiry[id]);
                else
                    left = pred_expiry[id] - pred_counter;
            end
        end
        expected_results.push_back(mk_result(st, left, 1'b0, '0, 1'b1));
    endtask

    // sender: one command transaction, with a random gap before each burst
    int burst_left;

    task automatic send_command(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                logic [TICK_W-1:0] tv, logic [TICK_W-1:0] cyc);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {cyc, tv, id};
        predict_command(op, id, tv, cyc);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain_and_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0 && !timed_out)
            @(posedge clk);
        // a ring pass plus remainder unit work may still be in flight
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic addr, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (addr == CFG_WRAP_LIMIT)
            pred_wrap_limit = value;
        else
            pred_min_cycle = value;
    endtask

    // random command, mostly on valid ids with meaningful values
    task automatic random_command();
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] tv;
        logic [TICK_W-1:0] cyc;
        int                sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            op = OP_TICK;
        else if (sel < 60)
            op = OP_SETREL;
        else if (sel < 72)
            op = OP_SETABS;
        else if (sel < 82)
            op = OP_CANCEL;
        else if (sel < 95)
            op = OP_QUERY;
        else
            op = OP_W'($urandom_range(5, 7));
        id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, NUM_ALARMS - 1));
        if ($urandom_range(0, 9) == 0)
            tv = TICK_W'($urandom);
        else
            tv = TICK_W'($urandom_range(0, pred_wrap_limit < 12 ? pred_wrap_limit : 12));
        case ($urandom_range(0, 5))
            0: cyc = TICK_W'($urandom);
            1, 2: cyc = '0;
            default: cyc = TICK_W'($urandom_range(1, pred_wrap_limit < 8 ? pred_wrap_limit : 8));
        endcase
        send_command(op, id, tv, cyc);
    endtask

    // directed rows: expected status typed in only where obvious
    cmd_row_t directed_rows [] = '{
        '{OP_TICK,   8'd0,   16'd0,     16'd0,     1'b1, STAT_OK},
        '{OP_QUERY,  8'd0,   16'd0,     16'd0,     1'b1, STAT_INACTIVE},
        '{OP_CANCEL, 8'd7,   16'd0,     16'd0,     1'b1, STAT_INACTIVE},
        '{OP_SETREL, 8'd8,   16'd5,     16'd0,     1'b1, STAT_BAD_ID},
        '{OP_SETREL, 8'd255, 16'd0,     16'd0,     1'b1, STAT_BAD_ID},
        '{OP_SETREL, 8'd0,   16'd0,     16'd0,     1'b1, STAT_BAD_VAL},
        '{OP_SETREL, 8'd0,   16'd2,     16'd0,     1'b0, STAT_OK},
        '{OP_SETREL, 8'd0,   16'd3,     16'd0,     1'b1, STAT_ACTIVE},
        '{OP_SETABS, 8'd1,   16'd3,     16'd2,     1'b0, STAT_OK},
        '{OP_SETREL, 8'd7,   16'hFFFF,  16'hFFFF,  1'b0, STAT_OK},
        '{OP_SETABS, 8'd2,   16'd2,     16'd0,     1'b0, STAT_OK},
        '{OP_QUERY,  8'd0,   16'd0,     16'd0,     1'b0, STAT_OK},
        '{OP_QUERY,  8'd7,   16'd0,     16'd0,     1'b0, STAT_OK},
        '{OP_TICK,   8'hAA,  16'hFFFF,  16'hFFFF,  1'b0, STAT_OK},
        '{OP_TICK,   8'd0,   16'd0,     16'd0,     1'b0, STAT_OK},
        '{OP_TICK,   8'd0,   16'd0,     16'd0,     1'b0, STAT_OK},
        '{OP_QUERY,  8'd1,   16'd0,     16'd0,     1'b0, STAT_OK},
        '{OP_CANCEL, 8'd1,   16'd0,     16'd0,     1'b0, STAT_OK},
        '{OP_CANCEL, 8'd7,   16'd0,     16'd0,     1'b0, STAT_OK},
        '{3'd5,      8'd3,   16'd1,     16'd1,     1'b1, STAT_OK},
        '{3'd7,      8'hFF,  16'hFFFF,  16'hFFFF,  1'b1, STAT_OK}
    };

    // stimulus: directed table, then phases under several register settings
    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_addr      = 1'b0;
        cfg_wdata     = '0;
        rst_n         = 1'b0;
        burst_left    = 0;
        pred_wrap_limit = WRAP_LIMIT_RST;
        pred_min_cycle  = MIN_CYCLE_RST;
        pred_counter    = '0;
        for (int i = 0; i < NUM_ALARMS; i++)
        begin
            pred_active[i] = 1'b0;
            pred_expiry[i] = '0;
            pred_period[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            send_command(directed_rows[r].op, directed_rows[r].id,
                         directed_rows[r].tv, directed_rows[r].cyc);
            // typed-in status must agree with the predictor as well
            if (directed_rows[r].has_exp &&
                expected_results[expected_results.size()-1].status != directed_rows[r].exp_status)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("row %0d: typed-in st %0d, predicted st %0d", r,
                             directed_rows[r].exp_status,
                             expected_results[expected_results.size()-1].status);
            end
        end
        drain_and_idle();

        // tiny counter: many wraps and cyclic re-arms, min_cycle rejects cycle 1
        write_reg(CFG_WRAP_LIMIT, 16'd7);
        write_reg(CFG_MIN_CYCLE, 16'd2);
        repeat (80) random_command();
        drain_and_idle();

        // smallest counter, counter sits above the new maximum
        write_reg(CFG_WRAP_LIMIT, 16'd1);
        write_reg(CFG_MIN_CYCLE, 16'd1);
        repeat (50) random_command();
        drain_and_idle();

        // largest min_cycle rejects every nonzero cycle
        write_reg(CFG_WRAP_LIMIT, 16'd15);
        write_reg(CFG_MIN_CYCLE, 16'hFFFF);
        repeat (40) random_command();
        drain_and_idle();

        write_reg(CFG_WRAP_LIMIT, 16'hFFFF);
        write_reg(CFG_MIN_CYCLE, 16'd3);
        repeat (30) random_command();
        drain_and_idle();

        write_reg(CFG_WRAP_LIMIT, 16'd11);
        write_reg(CFG_MIN_CYCLE, 16'd1);
        repeat (50) random_command();
        drain_and_idle();

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // receiver stalls on its own pattern: stall phases with no-stall stretches
    int stall_phase;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_phase   <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 64;
            if (stall_phase < 20)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // scoreboard: compare each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            rx_count++;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction: tdata %h", m_axis_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[2:0] !== want.status ||
                    m_axis_tdata[18:3] !== want.ticks_left ||
                    m_axis_tdata[26:19] !== want.expired_id ||
                    m_axis_tuser !== want.expired_valid ||
                    m_axis_tlast !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp st %0d left %0d ev %0d id %0d last %0d,",
                                  " got st %0d left %0d ev %0d id %0d last %0d"},
                                 want.status, want.ticks_left, want.expired_valid,
                                 want.expired_id, want.last, m_axis_tdata[2:0],
                                 m_axis_tdata[18:3], m_axis_tuser, m_axis_tdata[26:19],
                                 m_axis_tlast);
                end
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out <= 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        mismatch_count = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        rx_count = 0;
    end

endmodule
